/* rtl/rdss_pkg.sv */
// Shared types, character codes and keyword tables for the def signature scanner.
`timescale 1ns / 1ps
`default_nettype none

package rdss_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QAW         = $clog2(QUEUE_DEPTH);
	localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;

	// keyword text, first letter in the lowest byte
	localparam logic [63:0] MK_BEGIN = 64'h0000_0A6E_6967_6562; // "begin\n"
	localparam logic [63:0] MK_END   = 64'h0000_0000_0A64_6E65; // "end\n"
	localparam logic [63:0] KW_DEF   = 64'h0000_0000_0066_6564; // "def"
	localparam logic [63:0] KW_DO    = 64'h0000_0000_0000_6F64; // "do"
	localparam logic [63:0] KW_END   = 64'h0000_0000_0064_6E65; // "end"

	localparam logic [2:0] MK_BEGIN_LEN = 3'd6;
	localparam logic [2:0] MK_END_LEN   = 3'd4;
	localparam logic [2:0] KW_DEF_LEN   = 3'd3;
	localparam logic [2:0] KW_DO_LEN    = 3'd2;
	localparam logic [2:0] KW_END_LEN   = 3'd3;

	typedef enum logic [1:0] {
		CM_NONE,
		CM_LINE,
		CM_BEGIN,
		CM_END
	} cmode_t;

	typedef enum logic [1:0] {
		PM_SEEK,
		PM_NAME,
		PM_PARAMS,
		PM_SKIP
	} pmode_t;

	typedef enum logic [2:0] {
		EV_NAME_CHAR,
		EV_NAME_CANCEL,
		EV_PNAME_CHAR,
		EV_PTYPE_CHAR,
		EV_PARAM_COMMIT,
		EV_FUNC_DONE
	} evkind_t;

	typedef struct packed {
		evkind_t    kind;
		logic [7:0] ch;
		logic [4:0] pos;
		logic [4:0] total;
		logic       ovf;
	} event_t;

	// next matcher position: one further on a hit, else back to zero
	function automatic logic [2:0] advance(input logic [2:0] pos, input logic [7:0] c,
	                                       input logic [63:0] word, input logic [2:0] len);
		logic [2:0] r;
		r = 3'd0;
		if (pos < len && c == word[{pos, 3'b000} +: 8])
			r = pos + 3'd1;
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/ruby_def_signature_scanner_top.sv */
// Path: each event passes through the event queue and then the output register to the master side.
// Throughput: one byte per cycle while the event queue has space; the front end updates all parse state per byte.
// A 4-beat event queue and an output register decouple input and output stalls.
// Reset: arst_n clears parse state to seeking def outside comments and empties the queue.
// A byte with start-of-text set restarts parsing and is itself parsed from the reset state.
`timescale 1ns / 1ps
`default_nettype none

module ruby_def_signature_scanner_top
	import rdss_pkg::*;
#(
	parameter int NAME_MAX  = 64,
	parameter int PARAM_MAX = 16,
	parameter int KEY_MAX   = 32,
	parameter int TYPE_MAX  = 32,
	parameter int DEPTH_MAX = 255
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // text_char
	input  wire logic        s_axis_tuser,  // start_of_text
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // event_char[7:0], param_position[12:8],
	                                        // param_total[17:13], zero fill
	output logic [3:0]       m_axis_tuser   // event_kind[2:0], overflow_flag[3]
);

	logic   ev_valid;
	event_t ev;
	logic   q_space;
	logic   q_valid;
	logic   q_pop;
	event_t q_data;

	rdss_front #(
		.NAME_MAX  (NAME_MAX),
		.PARAM_MAX (PARAM_MAX),
		.KEY_MAX   (KEY_MAX),
		.TYPE_MAX  (TYPE_MAX),
		.DEPTH_MAX (DEPTH_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_char  (s_axis_tdata),
		.in_sot   (s_axis_tuser),
		.space    (q_space),
		.ev_valid (ev_valid),
		.ev       (ev)
	);

	rdss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ev_valid),
		.push_data (ev),
		.space     (q_space),
		.out_valid (q_valid),
		.pop       (q_pop),
		.out_data  (q_data)
	);

	rdss_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

/* rtl/rdss_front.sv */
// Front end: takes source bytes, tracks comments and parse state, classifies events.
`timescale 1ns / 1ps
`default_nettype none

module rdss_front
	import rdss_pkg::*;
#(
	parameter int NAME_MAX  = 64,
	parameter int PARAM_MAX = 16,
	parameter int KEY_MAX   = 32,
	parameter int TYPE_MAX  = 32,
	parameter int DEPTH_MAX = 255
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_char,
	input  wire logic       in_sot,
	input  wire logic       space,
	output logic            ev_valid,
	output event_t          ev
);

	localparam int NLW = $clog2(NAME_MAX);
	localparam int PCW = $clog2(PARAM_MAX + 1);
	localparam int KLW = $clog2(KEY_MAX);
	localparam int TLW = $clog2(TYPE_MAX);
	localparam int NDW = $clog2(DEPTH_MAX + 1);

	cmode_t           cm_q, cm_d;
	pmode_t           pm_q, pm_d;
	logic             obc_q, obc_d;
	logic [2:0]       bpos_q, bpos_d;
	logic [2:0]       epos_q, epos_d;
	logic [1:0]       defm_q, defm_d;
	logic [1:0]       dom_q, dom_d;
	logic [1:0]       endm_q, endm_d;
	logic [NLW-1:0]   nl_q, nl_d;
	logic [PCW-1:0]   pc_q, pc_d;
	logic [KLW-1:0]   pnl_q, pnl_d;
	logic [TLW-1:0]   ptl_q, ptl_d;
	logic             rt_q, rt_d;
	logic [NDW-1:0]   nd_q, nd_d;
	logic             pnl_nl_q;
	logic             prev_nl;
	logic             pass;
	logic             full;
	logic             accept;
	logic             emit;
	logic [2:0]       adv;
	logic [2:0]       adv_do, adv_def, adv_end;
	logic             inc, dec;
	logic [7:0]       c;

	assign c        = in_char;
	assign in_ready = space;
	assign accept   = in_valid && space;
	assign ev_valid = accept && emit;

	always_comb begin
		cm_d   = cm_q;
		pm_d   = pm_q;
		obc_d  = obc_q;
		bpos_d = bpos_q;
		epos_d = epos_q;
		defm_d = defm_q;
		dom_d  = dom_q;
		endm_d = endm_q;
		nl_d   = nl_q;
		pc_d   = pc_q;
		pnl_d  = pnl_q;
		ptl_d  = ptl_q;
		rt_d   = rt_q;
		nd_d   = nd_q;
		prev_nl = pnl_nl_q;
		if (in_sot) begin
			cm_d    = CM_NONE;
			pm_d    = PM_SEEK;
			obc_d   = 1'b1;
			bpos_d  = '0;
			epos_d  = '0;
			defm_d  = '0;
			dom_d   = '0;
			endm_d  = '0;
			nl_d    = '0;
			pc_d    = '0;
			pnl_d   = '0;
			ptl_d   = '0;
			rt_d    = 1'b0;
			nd_d    = NDW'(1);
			prev_nl = 1'b1;
		end

		emit     = 1'b0;
		ev       = '0;
		ev.kind  = EV_NAME_CHAR;
		adv      = '0;
		adv_do   = '0;
		adv_def  = '0;
		adv_end  = '0;
		inc      = 1'b0;
		dec      = 1'b0;
		full     = pc_d >= PCW'(PARAM_MAX);

		// comment tracking
		unique case (cm_d)
			CM_NONE: begin
				if (c == CH_HASH) begin
					cm_d = CM_LINE;
				end else if (c == CH_EQ && prev_nl) begin
					if (obc_d) begin
						cm_d   = CM_BEGIN;
						bpos_d = '0;
					end else begin
						cm_d   = CM_END;
						epos_d = '0;
					end
				end
			end
			CM_LINE: begin
				if (c == CH_LF)
					cm_d = CM_NONE;
			end
			CM_BEGIN: begin
				adv    = advance(bpos_d, c, MK_BEGIN, MK_BEGIN_LEN);
				bpos_d = adv;
				if (adv == 3'd0) begin
					cm_d = CM_NONE;
				end else if (adv == MK_BEGIN_LEN) begin
					cm_d   = CM_NONE;
					bpos_d = '0;
					obc_d  = 1'b0;
					epos_d = '0;
				end
			end
			CM_END: begin
				adv    = advance(epos_d, c, MK_END, MK_END_LEN);
				epos_d = adv;
				if (adv == 3'd0) begin
					cm_d = CM_NONE;
				end else if (adv == MK_END_LEN) begin
					cm_d   = CM_NONE;
					obc_d  = 1'b1;
					epos_d = '0;
				end
			end
			default: cm_d = CM_NONE;
		endcase

		pass = cm_d == CM_NONE && obc_d && c != CH_SP && c != CH_TAB && c != CH_CR &&
		       (c != CH_LF || pm_d == PM_NAME);

		if (!pass) begin
			defm_d = '0;
			dom_d  = '0;
			endm_d = '0;
		end else begin
			unique case (pm_d)
				PM_SEEK: begin
					adv_def = advance({1'b0, defm_d}, c, KW_DEF, KW_DEF_LEN);
					defm_d  = adv_def[1:0];
					if (adv_def == KW_DEF_LEN) begin
						pm_d   = PM_NAME;
						nl_d   = '0;
						defm_d = '0;
					end
				end
				PM_NAME: begin
					if (c == CH_LPAREN) begin
						if (nl_d == '0) begin
							pm_d   = PM_SEEK;
							defm_d = '0;
						end else begin
							pm_d  = PM_PARAMS;
							nl_d  = '0;
							pc_d  = '0;
							pnl_d = '0;
							ptl_d = '0;
							rt_d  = 1'b0;
						end
					end else if (c == CH_LF) begin
						if (nl_d == '0) begin
							pm_d   = PM_SEEK;
							defm_d = '0;
						end else begin
							emit    = 1'b1;
							ev.kind = EV_NAME_CANCEL;
							nl_d    = '0;
							pc_d    = '0;
							pm_d    = PM_SKIP;
							defm_d  = '0;
							dom_d   = '0;
							endm_d  = '0;
							nd_d    = NDW'(1);
						end
					end else if (nl_d < NLW'(NAME_MAX - 1)) begin
						nl_d  = nl_d + 1'b1;
						emit  = 1'b1;
						ev.ch = c;
					end else begin
						emit   = 1'b1;
						ev.ovf = 1'b1;
					end
				end
				PM_PARAMS: begin
					if (c == CH_RPAREN) begin
						if (pnl_d != '0) begin
							if (full)
								ev.ovf = 1'b1;
							else
								pc_d = pc_d + 1'b1;
						end
						emit     = 1'b1;
						ev.kind  = EV_FUNC_DONE;
						ev.total = 5'(pc_d);
						rt_d     = 1'b0;
						pnl_d    = '0;
						ptl_d    = '0;
						pm_d     = PM_SKIP;
						defm_d   = '0;
						dom_d    = '0;
						endm_d   = '0;
						nd_d     = NDW'(1);
					end else if (c == CH_COMMA) begin
						emit    = 1'b1;
						ev.kind = EV_PARAM_COMMIT;
						ev.pos  = 5'(pc_d);
						ev.ovf  = full;
						if (!full)
							pc_d = pc_d + 1'b1;
						rt_d  = 1'b0;
						pnl_d = '0;
						ptl_d = '0;
					end else if (c == CH_COLON) begin
						rt_d = 1'b1;
					end else if (rt_d) begin
						emit    = 1'b1;
						ev.kind = EV_PTYPE_CHAR;
						ev.pos  = 5'(pc_d);
						if (ptl_d < TLW'(TYPE_MAX - 1)) begin
							ptl_d  = ptl_d + 1'b1;
							ev.ch  = full ? 8'd0 : c;
							ev.ovf = full;
						end else begin
							ev.ovf = 1'b1;
						end
					end else begin
						emit    = 1'b1;
						ev.kind = EV_PNAME_CHAR;
						ev.pos  = 5'(pc_d);
						if (pnl_d < KLW'(KEY_MAX - 1)) begin
							pnl_d  = pnl_d + 1'b1;
							ev.ch  = full ? 8'd0 : c;
							ev.ovf = full;
						end else begin
							ev.ovf = 1'b1;
						end
					end
				end
				PM_SKIP: begin
					adv_do  = advance({1'b0, dom_d}, c, KW_DO, KW_DO_LEN);
					adv_def = advance({1'b0, defm_d}, c, KW_DEF, KW_DEF_LEN);
					adv_end = advance({1'b0, endm_d}, c, KW_END, KW_END_LEN);
					dom_d   = adv_do[1:0];
					defm_d  = adv_def[1:0];
					endm_d  = adv_end[1:0];
					inc     = (adv_do == KW_DO_LEN || adv_def == KW_DEF_LEN) &&
					          nd_d < NDW'(DEPTH_MAX);
					if (inc)
						nd_d = nd_d + 1'b1;
					dec = adv_end == KW_END_LEN && nd_d != '0;
					if (dec)
						nd_d = nd_d - 1'b1;
					if (nd_d == '0) begin
						pm_d   = PM_SEEK;
						defm_d = '0;
						dom_d  = '0;
						endm_d = '0;
					end
				end
				default: pm_d = PM_SEEK;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cm_q     <= CM_NONE;
			pm_q     <= PM_SEEK;
			obc_q    <= 1'b1;
			bpos_q   <= '0;
			epos_q   <= '0;
			defm_q   <= '0;
			dom_q    <= '0;
			endm_q   <= '0;
			nl_q     <= '0;
			pc_q     <= '0;
			pnl_q    <= '0;
			ptl_q    <= '0;
			rt_q     <= 1'b0;
			nd_q     <= NDW'(1);
			pnl_nl_q <= 1'b1;
		end else if (accept) begin
			cm_q     <= cm_d;
			pm_q     <= pm_d;
			obc_q    <= obc_d;
			bpos_q   <= bpos_d;
			epos_q   <= epos_d;
			defm_q   <= defm_d;
			dom_q    <= dom_d;
			endm_q   <= endm_d;
			nl_q     <= nl_d;
			pc_q     <= pc_d;
			pnl_q    <= pnl_d;
			ptl_q    <= ptl_d;
			rt_q     <= rt_d;
			nd_q     <= nd_d;
			pnl_nl_q <= c == CH_LF;
		end
	end

endmodule

`default_nettype wire

/* rtl/rdss_queue.sv */
// Short event queue between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module rdss_queue
	import rdss_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire event_t push_data,
	output logic        space,
	output logic        out_valid,
	input  wire logic   pop,
	output event_t      out_data
);

	event_t           mem_q [QUEUE_DEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic             do_push, do_pop;

	assign space     = count_q != QCW'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_ptr_q];
	assign do_push   = push && space;
	assign do_pop    = pop && out_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

/* rtl/rdss_back.sv */
// Output stage: registers one event and drives the master-side stream beat.
`timescale 1ns / 1ps
`default_nettype none

module rdss_back
	import rdss_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_valid,
	input  wire event_t q_data,
	output logic        q_pop,
	output logic        m_axis_tvalid,
	input  wire logic   m_axis_tready,
	output logic [23:0] m_axis_tdata,
	output logic [3:0]  m_axis_tuser
);

	logic   valid_q;
	event_t data_q;
	logic   take;

	assign take  = q_valid && (!valid_q || m_axis_tready);
	assign q_pop = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (take)
			valid_q <= 1'b1;
		else if (m_axis_tready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			data_q <= q_data;
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {6'd0, data_q.total, data_q.pos, data_q.ch};
	assign m_axis_tuser  = {data_q.ovf, data_q.kind};

endmodule

`default_nettype wire

/* rtl/rdss_checker.sv */
// Port-level checks on the scanner output stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rdss_checker
	import rdss_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic [3:0]  m_axis_tuser
);

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[2:0] != 3'd6 && m_axis_tuser[2:0] != 3'd7))
		else $error("event kind out of range");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[2:0] == EV_NAME_CANCEL ||
		m_axis_tuser[2:0] == EV_PARAM_COMMIT || m_axis_tuser[2:0] == EV_FUNC_DONE)
		|-> m_axis_tdata[7:0] == 8'd0)
		else $error("char set on a non-character event");

	a_total_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:0] != EV_FUNC_DONE |-> m_axis_tdata[17:13] == 5'd0)
		else $error("param total set outside function done");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled beat changed");

endmodule

bind ruby_def_signature_scanner_top rdss_checker u_rdss_checker (.*);

`default_nettype wire
